// ----- rtl/core/dmwv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dmwv_pkg: shared types and constants for the dns message wire validator
// parse phases, drop reason codes, name limits and result field layout
// ----------------------------------------------------------------------------
package dmwv_pkg;

	// name and offset limits
	localparam int MAX_NAME_LEN    = 255;
	localparam int MAX_LABEL_LEN   = 63;
	localparam int MAX_LABEL_COUNT = 127;
	localparam int OFFSET_BITS     = 16;

	// header layout
	localparam int HDR_BYTES  = 12;
	localparam int FIXED_PART = 10;

	// compression pointer lead bits
	localparam logic [7:0] PTR_MASK  = 8'hC0;
	localparam logic [7:0] PTR_LOW   = 8'h3F;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ACCEPT_QUERY    = 2'd0,
		CFG_ACCEPT_RESPONSE = 2'd1,
		CFG_SKIP_WALK       = 2'd2,
		CFG_UNUSED          = 2'd3
	} cfg_index_t;

	// parse phase of the byte walker
	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_QNAME   = 4'd1,
		PH_QPTR    = 4'd2,
		PH_QFIX    = 4'd3,
		PH_RNAME   = 4'd4,
		PH_RPTR    = 4'd5,
		PH_RFIX    = 4'd6,
		PH_RDATA   = 4'd7,
		PH_WALKED  = 4'd8,
		PH_SKIPPED = 4'd9,
		PH_ERR     = 4'd10
	} phase_t;

	// drop reason codes
	typedef enum logic [2:0] {
		DR_NONE     = 3'd0,
		DR_SHORT    = 3'd1,
		DR_QR       = 3'd2,
		DR_QDCOUNT  = 3'd3,
		DR_NAME     = 3'd4,
		DR_POINTER  = 3'd5,
		DR_RDLEN    = 3'd6,
		DR_TRAILING = 3'd7
	} drop_reason_t;

	// result tdata layout, lowest bit first
	localparam int F_ACCEPTED  = 0;
	localparam int F_REASON    = 1;
	localparam int F_MSG_ID    = 4;
	localparam int F_FLAGS     = 20;
	localparam int F_HAS_Q     = 36;
	localparam int F_QTYPE     = 37;
	localparam int F_QCLASS    = 53;
	localparam int F_ANCOUNT   = 69;
	localparam int F_NSCOUNT   = 85;
	localparam int F_ARCOUNT   = 101;
	localparam int F_QEND      = 117;
	localparam int RESULT_BITS = 133;
	localparam int OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

endpackage : dmwv_pkg
`default_nettype wire

// ----- rtl/core/dns_message_wire_validator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dns_message_wire_validator: streaming dns message format checker
// the result is registered and valid in the cycle after the last byte is taken
// throughput: one message byte per cycle, unless a result waits unaccepted at the output
// reset: arst_n clears the parse state and the result valid flag at once and
//   loads the accept flags (query 1, response 0, skip walk 0)
// ----------------------------------------------------------------------------
module dns_message_wire_validator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_addr,
	input  wire logic                            cfg_wdata,
	// message bytes in
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  wire logic                            s_axis_tlast,  // last_byte
	// verdict out
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [0] accepted, [3:1] drop_reason, [19:4] message_id, [35:20] header_flags,
	// [36] has_question, [52:37] question_type, [68:53] question_class,
	// [84:69] answer_count, [100:85] authority_count,
	// [116:101] additional_count, [132:117] question_end, [135:133] zero
	output logic [dmwv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import dmwv_pkg::*;

	typedef struct packed {
		logic        found;
		logic [1:0]  sect;
		logic [15:0] count;
	} sect_sel_t;

	localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT = '1;

	// configuration registers
	logic acc_query_q, acc_resp_q, skip_walk_q;

	// parse state
	logic [OFFSET_BITS-1:0] off_q,    off_nx;
	phase_t                 phase_q,  phase_nx;
	logic [7:0]             hdr_q  [HDR_BYTES];
	logic [7:0]             hdr_nx [HDR_BYTES];
	logic [15:0]            recs_q,   recs_nx;
	logic [1:0]             sect_q,   sect_nx;
	logic [8:0]             ntot_q,   ntot_nx;
	logic [7:0]             lcnt_q,   lcnt_nx;
	logic [5:0]             lleft_q,  lleft_nx;
	logic [5:0]             ptrh_q,   ptrh_nx;
	logic [3:0]             fcnt_q,   fcnt_nx;
	logic [15:0]            rdleft_q, rdleft_nx;
	drop_reason_t           err_q,    err_nx;
	logic [15:0]            qtype_q,  qtype_nx;
	logic [15:0]            qclass_q, qclass_nx;
	logic [15:0]            qend_q,   qend_nx;

	// output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TDATA_W-1:0] result;

	logic       in_take;
	logic [7:0] c;

	// first nonzero section count at or after start
	function automatic sect_sel_t pick_section(input logic [1:0] start,
		input logic [15:0] c0, input logic [15:0] c1, input logic [15:0] c2);
		sect_sel_t r;
		r = '0;
		if (start == 2'd0 && c0 != 16'd0) begin
			r.found = 1'b1;
			r.sect  = 2'd0;
			r.count = c0;
		end else if (start <= 2'd1 && c1 != 16'd0) begin
			r.found = 1'b1;
			r.sect  = 2'd1;
			r.count = c1;
		end else if (start <= 2'd2 && c2 != 16'd0) begin
			r.found = 1'b1;
			r.sect  = 2'd2;
			r.count = c2;
		end
		return r;
	endfunction

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign c             = s_axis_tdata;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// byte walker next state
	logic               do_fail, do_name_done, do_rec_done, do_after_q, do_enter;
	logic               do_start_q;
	drop_reason_t       fail_code;
	logic [1:0]         enter_from;
	logic               is_question;
	logic [OFFSET_BITS:0] off_inc;
	logic [9:0]         ntot_sum;
	logic [7:0]         lcnt_inc;
	logic [15:0]        rd_tmp;
	logic [15:0]        qd_word;
	logic [16:0]        ptr_tgt, ptr_lim;
	sect_sel_t          sel;

	always_comb begin
		hdr_nx    = hdr_q;
		off_nx    = off_q;
		phase_nx  = phase_q;
		recs_nx   = recs_q;
		sect_nx   = sect_q;
		ntot_nx   = ntot_q;
		lcnt_nx   = lcnt_q;
		lleft_nx  = lleft_q;
		ptrh_nx   = ptrh_q;
		fcnt_nx   = fcnt_q;
		rdleft_nx = rdleft_q;
		err_nx    = err_q;
		qtype_nx  = qtype_q;
		qclass_nx = qclass_q;
		qend_nx   = qend_q;

		do_fail      = 1'b0;
		fail_code    = DR_NONE;
		do_name_done = 1'b0;
		do_rec_done  = 1'b0;
		do_after_q   = 1'b0;
		do_enter     = 1'b0;
		do_start_q   = 1'b0;
		enter_from   = 2'd0;
		is_question  = (phase_q == PH_QNAME) || (phase_q == PH_QPTR);
		off_inc      = {1'b0, off_q} + 1'b1;
		ntot_sum     = {1'b0, ntot_q} + 10'd1 + {2'b0, c};
		lcnt_inc     = lcnt_q + 8'd1;
		rd_tmp       = rdleft_q;
		qd_word      = 16'd0;
		ptr_tgt      = 17'({ptrh_q, c});
		ptr_lim      = 17'(off_q) - 17'd1;
		sel          = '0;

		if (off_q >= OFFSET_LIMIT) begin
			// message longer than the offset range
			do_fail   = 1'b1;
			fail_code = DR_TRAILING;
		end else begin
			off_nx = off_inc[OFFSET_BITS-1:0];
			case (phase_q)
				PH_HDR: begin
					if (off_q < OFFSET_BITS'(HDR_BYTES))
						hdr_nx[off_q[3:0]] = c;
					if (off_q == OFFSET_BITS'(HDR_BYTES - 1)) begin
						qd_word = {hdr_nx[4], hdr_nx[5]};
						if (hdr_nx[2][7] ? !acc_resp_q : !acc_query_q) begin
							do_fail   = 1'b1;
							fail_code = DR_QR;
						end else if (qd_word == 16'd1) begin
							do_start_q = 1'b1;
						end else if (qd_word == 16'd0) begin
							do_after_q = 1'b1;
						end else begin
							do_fail   = 1'b1;
							fail_code = DR_QDCOUNT;
						end
					end
				end
				PH_QNAME, PH_RNAME: begin
					if (lleft_q != 6'd0) begin
						lleft_nx = lleft_q - 6'd1;
					end else if ((c & PTR_MASK) == PTR_MASK) begin
						ptrh_nx  = 6'(c & PTR_LOW);
						phase_nx = is_question ? PH_QPTR : PH_RPTR;
					end else if ((c & PTR_MASK) != 8'd0) begin
						do_fail   = 1'b1;
						fail_code = DR_NAME;
					end else if (c == 8'd0) begin
						if ({1'b0, ntot_q} + 10'd1 > 10'(MAX_NAME_LEN)) begin
							do_fail   = 1'b1;
							fail_code = DR_NAME;
						end else begin
							do_name_done = 1'b1;
						end
					end else if (c > 8'(MAX_LABEL_LEN)) begin
						do_fail   = 1'b1;
						fail_code = DR_NAME;
					end else begin
						ntot_nx = ntot_sum[8:0];
						if (ntot_sum + 10'd1 > 10'(MAX_NAME_LEN)) begin
							do_fail   = 1'b1;
							fail_code = DR_NAME;
						end else begin
							lcnt_nx = lcnt_inc;
							if (lcnt_inc > 8'(MAX_LABEL_COUNT)) begin
								do_fail   = 1'b1;
								fail_code = DR_NAME;
							end else begin
								lleft_nx = 6'(c);
							end
						end
					end
				end
				PH_QPTR, PH_RPTR: begin
					// pointer must aim strictly before its own lead byte
					if (ptr_tgt >= ptr_lim) begin
						do_fail   = 1'b1;
						fail_code = DR_POINTER;
					end else begin
						do_name_done = 1'b1;
					end
				end
				PH_QFIX: begin
					case (fcnt_q)
						4'd0:    qtype_nx  = {c, 8'd0};
						4'd1:    qtype_nx  = qtype_q | {8'd0, c};
						4'd2:    qclass_nx = {c, 8'd0};
						default: qclass_nx = qclass_q | {8'd0, c};
					endcase
					fcnt_nx = fcnt_q + 4'd1;
					if (fcnt_q + 4'd1 >= 4'd4)
						do_after_q = 1'b1;
				end
				PH_RFIX: begin
					if (fcnt_q == 4'd8)
						rd_tmp = {c, 8'd0};
					else if (fcnt_q == 4'd9)
						rd_tmp = rdleft_q | {8'd0, c};
					rdleft_nx = rd_tmp;
					fcnt_nx   = fcnt_q + 4'd1;
					if (fcnt_q + 4'd1 >= 4'(FIXED_PART)) begin
						if (rd_tmp == 16'd0)
							do_rec_done = 1'b1;
						else
							phase_nx = PH_RDATA;
					end
				end
				PH_RDATA: begin
					rd_tmp    = rdleft_q - 16'd1;
					rdleft_nx = rd_tmp;
					if (rd_tmp == 16'd0)
						do_rec_done = 1'b1;
				end
				PH_WALKED: begin
					do_fail   = 1'b1;
					fail_code = DR_TRAILING;
				end
				default: ;
			endcase
		end

		// question name begins after the header
		if (do_start_q) begin
			ntot_nx  = 9'd0;
			lcnt_nx  = 8'd0;
			lleft_nx = 6'd0;
			ptrh_nx  = 6'd0;
			phase_nx = PH_QNAME;
		end

		// name finished, fixed part follows
		if (do_name_done) begin
			fcnt_nx = 4'd0;
			if (is_question) begin
				phase_nx = PH_QFIX;
			end else begin
				rdleft_nx = 16'd0;
				phase_nx  = PH_RFIX;
			end
		end

		// one record finished
		if (do_rec_done) begin
			recs_nx = recs_q - 16'd1;
			if (recs_nx == 16'd0) begin
				do_enter   = 1'b1;
				enter_from = sect_q + 2'd1;
			end else begin
				ntot_nx  = 9'd0;
				lcnt_nx  = 8'd0;
				lleft_nx = 6'd0;
				ptrh_nx  = 6'd0;
				phase_nx = PH_RNAME;
			end
		end

		// question section finished
		if (do_after_q) begin
			qend_nx = 16'(off_inc);
			if (skip_walk_q) begin
				phase_nx = PH_SKIPPED;
			end else begin
				do_enter   = 1'b1;
				enter_from = 2'd0;
			end
		end

		// move on to the next section holding records
		if (do_enter) begin
			sel = pick_section(enter_from, {hdr_nx[6], hdr_nx[7]},
				{hdr_nx[8], hdr_nx[9]}, {hdr_nx[10], hdr_nx[11]});
			if (sel.found) begin
				sect_nx  = sel.sect;
				recs_nx  = sel.count;
				ntot_nx  = 9'd0;
				lcnt_nx  = 8'd0;
				lleft_nx = 6'd0;
				ptrh_nx  = 6'd0;
				phase_nx = PH_RNAME;
			end else begin
				phase_nx = PH_WALKED;
			end
		end

		// first error wins
		if (do_fail) begin
			if (err_q == DR_NONE)
				err_nx = fail_code;
			phase_nx = PH_ERR;
		end
	end

	// verdict and reported fields
	drop_reason_t reason;
	logic         hdr_ok, q_ok;

	always_comb begin
		reason = err_nx;
		if (err_nx == DR_NONE) begin
			case (phase_nx)
				PH_HDR, PH_QFIX:    reason = DR_SHORT;
				PH_QNAME, PH_RNAME: reason = DR_NAME;
				PH_QPTR, PH_RPTR:   reason = DR_POINTER;
				PH_RFIX, PH_RDATA:  reason = DR_RDLEN;
				default:            reason = DR_NONE;
			endcase
		end
		hdr_ok = (phase_nx != PH_HDR);
		q_ok   = (qend_nx != 16'd0);

		result = '0;
		result[F_ACCEPTED]     = (reason == DR_NONE);
		result[F_REASON +: 3]  = reason;
		result[F_MSG_ID +: 16] = hdr_ok ? {hdr_nx[0], hdr_nx[1]} : 16'd0;
		result[F_FLAGS +: 16]  = hdr_ok ? {hdr_nx[2], hdr_nx[3]} : 16'd0;
		result[F_HAS_Q]        = hdr_ok && ({hdr_nx[4], hdr_nx[5]} == 16'd1);
		result[F_QTYPE +: 16]  = q_ok ? qtype_nx : 16'd0;
		result[F_QCLASS +: 16] = q_ok ? qclass_nx : 16'd0;
		result[F_ANCOUNT +: 16] = hdr_ok ? {hdr_nx[6], hdr_nx[7]} : 16'd0;
		result[F_NSCOUNT +: 16] = hdr_ok ? {hdr_nx[8], hdr_nx[9]} : 16'd0;
		result[F_ARCOUNT +: 16] = hdr_ok ? {hdr_nx[10], hdr_nx[11]} : 16'd0;
		result[F_QEND +: 16]    = qend_nx;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_query_q <= 1'b1;
			acc_resp_q  <= 1'b0;
			skip_walk_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_addr))
				CFG_ACCEPT_QUERY:    acc_query_q <= cfg_wdata;
				CFG_ACCEPT_RESPONSE: acc_resp_q  <= cfg_wdata;
				CFG_SKIP_WALK:       skip_walk_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// parse state, cleared after the last byte of each message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			phase_q  <= PH_HDR;
			for (int i = 0; i < HDR_BYTES; i++)
				hdr_q[i] <= 8'd0;
			recs_q   <= 16'd0;
			sect_q   <= 2'd0;
			ntot_q   <= 9'd0;
			lcnt_q   <= 8'd0;
			lleft_q  <= 6'd0;
			ptrh_q   <= 6'd0;
			fcnt_q   <= 4'd0;
			rdleft_q <= 16'd0;
			err_q    <= DR_NONE;
			qtype_q  <= 16'd0;
			qclass_q <= 16'd0;
			qend_q   <= 16'd0;
		end else if (in_take) begin
			if (s_axis_tlast) begin
				off_q    <= '0;
				phase_q  <= PH_HDR;
				for (int i = 0; i < HDR_BYTES; i++)
					hdr_q[i] <= 8'd0;
				recs_q   <= 16'd0;
				sect_q   <= 2'd0;
				ntot_q   <= 9'd0;
				lcnt_q   <= 8'd0;
				lleft_q  <= 6'd0;
				ptrh_q   <= 6'd0;
				fcnt_q   <= 4'd0;
				rdleft_q <= 16'd0;
				err_q    <= DR_NONE;
				qtype_q  <= 16'd0;
				qclass_q <= 16'd0;
				qend_q   <= 16'd0;
			end else begin
				off_q    <= off_nx;
				phase_q  <= phase_nx;
				hdr_q    <= hdr_nx;
				recs_q   <= recs_nx;
				sect_q   <= sect_nx;
				ntot_q   <= ntot_nx;
				lcnt_q   <= lcnt_nx;
				lleft_q  <= lleft_nx;
				ptrh_q   <= ptrh_nx;
				fcnt_q   <= fcnt_nx;
				rdleft_q <= rdleft_nx;
				err_q    <= err_nx;
				qtype_q  <= qtype_nx;
				qclass_q <= qclass_nx;
				qend_q   <= qend_nx;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_take && s_axis_tlast)
			out_data_q <= result;
	end

endmodule : dns_message_wire_validator
`default_nettype wire

// ----- rtl/core/dmwv_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dmwv_checker: port-level checks for the dns message wire validator
// watches both stream sides and the verdict fields over time
// ----------------------------------------------------------------------------
module dmwv_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_axis_tvalid,
	input wire logic                         s_axis_tready,
	input wire logic                         s_axis_tlast,
	input wire logic                         m_axis_tvalid,
	input wire logic                         m_axis_tready,
	input wire logic [dmwv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import dmwv_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// verdict agrees with the drop reason
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[F_ACCEPTED] == (m_axis_tdata[F_REASON +: 3] == DR_NONE)))
		else $error("accepted flag and drop reason disagree");

	// an accepted message always got past its question section
	a_qend: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[F_ACCEPTED] |-> m_axis_tdata[F_QEND +: 16] != 16'd0)
		else $error("accepted message without question end");

	// input backpressure only comes from a waiting result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	// a new result follows a last byte request
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
		else $error("result without a last byte");

endmodule : dmwv_checker

bind dns_message_wire_validator dmwv_checker u_dmwv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for dns_message_wire_validator
// feeds dns messages byte by byte over the input stream, runs a software
// parser of the message format in parallel and compares every verdict field
// with it; directed cases first, then random well-formed and broken messages
// ----------------------------------------------------------------------------
module tb_top;
	import dmwv_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	typedef logic [7:0] octet_q_t[$];

	// one expected verdict
	typedef struct packed {
		logic         accepted;
		drop_reason_t reason;
		logic [15:0]  msg_id;
		logic [15:0]  flags;
		logic         has_q;
		logic [15:0]  qtype;
		logic [15:0]  qclass;
		logic [15:0]  ancount;
		logic [15:0]  nscount;
		logic [15:0]  arcount;
		logic [15:0]  qend;
	} verdict_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [1:0]             cfg_addr = '0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = '0;  // [7:0] data_byte
	logic                   s_axis_tlast = 1'b0;  // last_byte
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	// [0] accepted, [3:1] drop_reason, [19:4] message_id, [35:20] header_flags,
	// [36] has_question, [52:37] question_type, [68:53] question_class,
	// [84:69] answer_count, [100:85] authority_count,
	// [116:101] additional_count, [132:117] question_end, [135:133] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	verdict_t verdict_q[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       bytes_pushed = 0;
	bit       jitter_on = 1'b1;
	int       hold_req = 0;
	int       hold_left = 0;
	int       stall_left = 0;

	// parser copy of the block: registers and walk state
	bit           acc_query = 1'b1;
	bit           acc_resp = 1'b0;
	bit           skip_walk = 1'b0;
	logic [15:0]  walk_off;
	phase_t       walk_phase;
	logic [7:0]   hdr_bytes [12];
	logic [15:0]  recs_left;
	int           sect_idx;
	int           name_len;
	int           label_num;
	int           label_rem;
	logic [5:0]   ptr_hi;
	int           fix_cnt;
	logic [15:0]  rdata_rem;
	drop_reason_t first_drop;
	logic [15:0]  q_type_w;
	logic [15:0]  q_class_w;
	logic [15:0]  q_end_off;

	dns_message_wire_validator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// ------------------------------------------------------------------
	// message parser
	// ------------------------------------------------------------------
	function automatic logic [15:0] hword(int i);
		return {hdr_bytes[i], hdr_bytes[i + 1]};
	endfunction

	function automatic void latch_drop(drop_reason_t r);
		if (first_drop == DR_NONE) first_drop = r;
		walk_phase = PH_ERR;
	endfunction

	function automatic void begin_name(phase_t ph);
		name_len = 0;
		label_num = 0;
		label_rem = 0;
		ptr_hi = '0;
		walk_phase = ph;
	endfunction

	// first section from here on with a nonzero record count
	function automatic void open_section(int first);
		for (int s = first; s < 3; s++) begin
			if (hword(6 + 2 * s) != 16'd0) begin
				sect_idx = s;
				recs_left = hword(6 + 2 * s);
				begin_name(PH_RNAME);
				return;
			end
		end
		walk_phase = PH_WALKED;
	endfunction

	function automatic void question_closed();
		q_end_off = walk_off + 16'd1;
		if (skip_walk) walk_phase = PH_SKIPPED;
		else open_section(0);
	endfunction

	function automatic void record_closed();
		recs_left = recs_left - 16'd1;
		if (recs_left == 16'd0) open_section(sect_idx + 1);
		else begin_name(PH_RNAME);
	endfunction

	function automatic void name_closed(bit in_q);
		fix_cnt = 0;
		if (in_q) begin
			walk_phase = PH_QFIX;
		end else begin
			rdata_rem = '0;
			walk_phase = PH_RFIX;
		end
	endfunction

	// label lengths, name limits and pointer lead bytes
	function automatic void name_byte(logic [7:0] c, bit in_q);
		if (label_rem > 0) begin
			label_rem--;
			return;
		end
		if ((c & PTR_MASK) == PTR_MASK) begin
			ptr_hi = c[5:0];
			walk_phase = in_q ? PH_QPTR : PH_RPTR;
			return;
		end
		if ((c & PTR_MASK) != 8'h00) begin
			latch_drop(DR_NAME);
			return;
		end
		if (c == 8'h00) begin
			if (name_len + 1 > MAX_NAME_LEN) latch_drop(DR_NAME);
			else name_closed(in_q);
			return;
		end
		if (int'(c) > MAX_LABEL_LEN) begin
			latch_drop(DR_NAME);
			return;
		end
		name_len += 1 + int'(c);
		if (name_len + 1 > MAX_NAME_LEN) begin
			latch_drop(DR_NAME);
			return;
		end
		label_num++;
		if (label_num > MAX_LABEL_COUNT) begin
			latch_drop(DR_NAME);
			return;
		end
		label_rem = int'(c);
	endfunction

	// compression pointers may only point backward
	function automatic void pointer_byte(logic [7:0] c, bit in_q);
		if (int'({ptr_hi, c}) >= int'(walk_off) - 1) latch_drop(DR_POINTER);
		else name_closed(in_q);
	endfunction

	function automatic void walk_byte(logic [7:0] c);
		logic [15:0] qd;
		case (walk_phase)
			PH_HDR: begin
				if (int'(walk_off) < HDR_BYTES) hdr_bytes[walk_off] = c;
				if (int'(walk_off) == HDR_BYTES - 1) begin
					qd = hword(4);
					if (hdr_bytes[2][7] ? !acc_resp : !acc_query) latch_drop(DR_QR);
					else if (qd == 16'd1) begin_name(PH_QNAME);
					else if (qd == 16'd0) question_closed();
					else latch_drop(DR_QDCOUNT);
				end
			end
			PH_QNAME: name_byte(c, 1'b1);
			PH_RNAME: name_byte(c, 1'b0);
			PH_QPTR: pointer_byte(c, 1'b1);
			PH_RPTR: pointer_byte(c, 1'b0);
			PH_QFIX: begin
				case (fix_cnt)
					0: q_type_w = {c, 8'h00};
					1: q_type_w = q_type_w | {8'h00, c};
					2: q_class_w = {c, 8'h00};
					default: q_class_w = q_class_w | {8'h00, c};
				endcase
				fix_cnt++;
				if (fix_cnt >= 4) question_closed();
			end
			PH_RFIX: begin
				if (fix_cnt == 8) rdata_rem = {c, 8'h00};
				else if (fix_cnt == 9) rdata_rem = rdata_rem | {8'h00, c};
				fix_cnt++;
				if (fix_cnt >= FIXED_PART) begin
					if (rdata_rem == 16'd0) record_closed();
					else walk_phase = PH_RDATA;
				end
			end
			PH_RDATA: begin
				rdata_rem = rdata_rem - 16'd1;
				if (rdata_rem == 16'd0) record_closed();
			end
			PH_WALKED: latch_drop(DR_TRAILING);
			default: ;
		endcase
	endfunction

	function automatic void clear_walk();
		walk_off = '0;
		foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
		recs_left = '0;
		sect_idx = 0;
		begin_name(PH_HDR);
		fix_cnt = 0;
		rdata_rem = '0;
		first_drop = DR_NONE;
		q_type_w = '0;
		q_class_w = '0;
		q_end_off = '0;
	endfunction

	// one accepted byte; returns 1 with the verdict on the last byte
	function automatic bit parse_byte(input logic [7:0] c, input logic last,
			output verdict_t v);
		drop_reason_t why;
		bit hdr_ok;
		bit q_ok;
		v = '0;
		if (int'(walk_off) >= (1 << OFFSET_BITS) - 1) begin
			latch_drop(DR_TRAILING);
		end else begin
			if (walk_phase != PH_ERR) walk_byte(c);
			walk_off = walk_off + 16'd1;
		end
		if (!last) return 1'b0;
		why = first_drop;
		if (why == DR_NONE) begin
			case (walk_phase)
				PH_HDR, PH_QFIX: why = DR_SHORT;
				PH_QNAME, PH_RNAME: why = DR_NAME;
				PH_QPTR, PH_RPTR: why = DR_POINTER;
				PH_RFIX, PH_RDATA: why = DR_RDLEN;
				default: why = DR_NONE;
			endcase
		end
		hdr_ok = walk_phase != PH_HDR;
		q_ok = q_end_off != 16'd0;
		v.accepted = why == DR_NONE;
		v.reason = why;
		v.msg_id = hdr_ok ? hword(0) : '0;
		v.flags = hdr_ok ? hword(2) : '0;
		v.has_q = hdr_ok && hword(4) == 16'd1;
		v.qtype = q_ok ? q_type_w : '0;
		v.qclass = q_ok ? q_class_w : '0;
		v.ancount = hdr_ok ? hword(6) : '0;
		v.nscount = hdr_ok ? hword(8) : '0;
		v.arcount = hdr_ok ? hword(10) : '0;
		v.qend = q_end_off;
		clear_walk();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// stream driving and checking
	// ------------------------------------------------------------------
	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// verdict receiver: long hold on request, random stalls otherwise
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else begin
			m_axis_tready = 1'b1;
			if (jitter_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
		end
	end

	function automatic void compare_field(string fname, logic [15:0] want,
			logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, fname, want, got);
			mismatch_count++;
		end
	endfunction

	// compare each verdict with the oldest expected one
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: verdict expected none actual %h", $time, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = verdict_q.pop_front();
				compare_field("accepted", 16'(want.accepted), 16'(m_axis_tdata[F_ACCEPTED]));
				compare_field("drop_reason", 16'(want.reason), 16'(m_axis_tdata[F_REASON +: 3]));
				compare_field("message_id", want.msg_id, m_axis_tdata[F_MSG_ID +: 16]);
				compare_field("header_flags", want.flags, m_axis_tdata[F_FLAGS +: 16]);
				compare_field("has_question", 16'(want.has_q), 16'(m_axis_tdata[F_HAS_Q]));
				compare_field("question_type", want.qtype, m_axis_tdata[F_QTYPE +: 16]);
				compare_field("question_class", want.qclass, m_axis_tdata[F_QCLASS +: 16]);
				compare_field("answer_count", want.ancount, m_axis_tdata[F_ANCOUNT +: 16]);
				compare_field("authority_count", want.nscount, m_axis_tdata[F_NSCOUNT +: 16]);
				compare_field("additional_count", want.arcount, m_axis_tdata[F_ARCOUNT +: 16]);
				compare_field("question_end", want.qend, m_axis_tdata[F_QEND +: 16]);
			end
		end
	end

	// one byte request; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] d, input logic last);
		int idle;
		verdict_t v;
		idle = jitter_on ? pick_gap() : 0;
		if (idle > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (idle) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = d;
		s_axis_tlast = last;
		do @(posedge clk); while (!s_axis_tready);
		if (parse_byte(d, last, v)) verdict_q.push_back(v);
		bytes_pushed++;
		@(negedge clk);
	endtask

	task automatic send_message(input octet_q_t m);
		foreach (m[i]) send_byte(m[i], i == m.size() - 1);
	endtask

	// let every outstanding verdict drain, then wait with the input idle
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic v);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_ACCEPT_QUERY: acc_query = v;
			CFG_ACCEPT_RESPONSE: acc_resp = v;
			CFG_SKIP_WALK: skip_walk = v;
			default: ;
		endcase
	endtask

	task automatic configure(input bit q, input bit r, input bit skip);
		wait_idle();
		write_reg(CFG_ACCEPT_QUERY, q);
		write_reg(CFG_ACCEPT_RESPONSE, r);
		write_reg(CFG_SKIP_WALK, skip);
	endtask

	// ------------------------------------------------------------------
	// message building
	// ------------------------------------------------------------------
	function automatic void put16(ref octet_q_t m, input logic [15:0] w);
		m.push_back(w[15:8]);
		m.push_back(w[7:0]);
	endfunction

	function automatic void put_random(ref octet_q_t m, input int n);
		repeat (n) m.push_back(8'($urandom));
	endfunction

	function automatic void put_header(ref octet_q_t m, input logic [15:0] id,
			input logic [15:0] flags, input logic [15:0] qd, input logic [15:0] an,
			input logic [15:0] ns, input logic [15:0] ar);
		put16(m, id);
		put16(m, flags);
		put16(m, qd);
		put16(m, an);
		put16(m, ns);
		put16(m, ar);
	endfunction

	function automatic void put_label(ref octet_q_t m, input int len);
		m.push_back(8'(len));
		put_random(m, len);
	endfunction

	// 8 bytes of type, class, ttl and then the rdata length
	function automatic void put_fixed(ref octet_q_t m, input logic [15:0] rdlen);
		put_random(m, 8);
		put16(m, rdlen);
	endfunction

	// a few labels, ended by the root or by a pointer (mostly backward)
	function automatic void put_random_name(ref octet_q_t m);
		int labels;
		int pick;
		int target;
		labels = ($urandom_range(0, 11) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
		repeat (labels)
			put_label(m, ($urandom_range(0, 9) == 0) ? $urandom_range(40, 63)
				: $urandom_range(1, 12));
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			m.push_back(8'h00);
		end else begin
			target = (pick < 9) ? $urandom_range(0, m.size() - 1)
				: m.size() + $urandom_range(0, 30);
			m.push_back(PTR_MASK | 8'(target >> 8));
			m.push_back(8'(target));
		end
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_header_and_qr();
		octet_q_t m;
		put_header(m, 16'hFFFF, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0);
		send_message(m);
		m = {};
		put_header(m, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0);
		send_message(m);
		// response while only queries are accepted
		m = {};
		put_header(m, 16'h1234, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0);
		send_message(m);
		configure(1'b0, 1'b1, 1'b0);
		m = {};
		put_header(m, 16'hA5A5, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
		send_message(m);
		m = {};
		put_header(m, 16'h5A5A, 16'h0100, 16'd0, 16'd0, 16'd0, 16'd0);
		send_message(m);
		// unused index must change nothing
		wait_idle();
		write_reg(CFG_UNUSED, 1'b1);
		configure(1'b1, 1'b0, 1'b0);
	endtask

	task automatic test_short_messages();
		octet_q_t m;
		send_byte(8'hFF, 1'b1);
		put_random(m, 11);
		send_message(m);
		// ends inside qtype/qclass
		m = {};
		put_header(m, 16'h0101, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
		put_label(m, 1);
		m.push_back(8'h00);
		put_random(m, 3);
		send_message(m);
		// ends inside a question label
		m = {};
		put_header(m, 16'h0202, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
		m.push_back(8'd3);
		put_random(m, 2);
		send_message(m);
		// record name due right after the header
		m = {};
		put_header(m, 16'h0303, 16'h0000, 16'd0, 16'd1, 16'd0, 16'd0);
		send_message(m);
	endtask

	task automatic test_question_counts();
		octet_q_t m;
		put_header(m, 16'h0404, 16'h0000, 16'd2, 16'd0, 16'd0, 16'd0);
		put_random(m, 6);
		send_message(m);
		m = {};
		put_header(m, 16'h0505, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_message(m);
		m = {};
		put_header(m, 16'h0606, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
		put_label(m, 3);
		m.push_back(8'h00);
		put16(m, 16'hFFFF);
		put16(m, 16'h0000);
		send_message(m);
	endtask

	task automatic test_name_rules();
		octet_q_t m;
		// longest legal name, then one byte too long
		for (int last_len = 61; last_len <= 62; last_len++) begin
			m = {};
			put_header(m, 16'h0707, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
			repeat (3) put_label(m, MAX_LABEL_LEN);
			put_label(m, last_len);
			m.push_back(8'h00);
			put16(m, 16'h0001);
			put16(m, 16'h0001);
			send_message(m);
		end
		// reserved lead bits 01 and 10
		for (int lead = 8'h40; lead <= 8'h80; lead += 8'h40) begin
			m = {};
			put_header(m, 16'h0808, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
			m.push_back(8'(lead));
			put_random(m, 6);
			send_message(m);
		end
		// pointer to itself, then pointer back into the header
		for (int target = 12; target >= 0; target -= 12) begin
			m = {};
			put_header(m, 16'h0909, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
			m.push_back(PTR_MASK);
			m.push_back(8'(target));
			put16(m, 16'h001C);
			put16(m, 16'h0001);
			send_message(m);
		end
		// message ends right after a pointer lead byte
		m = {};
		put_header(m, 16'h0A0A, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
		m.push_back(PTR_MASK);
		send_message(m);
	endtask

	// one record in each section
	function automatic octet_q_t three_sections();
		octet_q_t m;
		put_header(m, 16'hBEEF, 16'h0000, 16'd1, 16'd1, 16'd1, 16'd1);
		put_label(m, 5);
		put_label(m, 3);
		m.push_back(8'h00);
		put16(m, 16'h0001);
		put16(m, 16'h0001);
		m.push_back(PTR_MASK);
		m.push_back(8'd12);
		put_fixed(m, 16'd4);
		put_random(m, 4);
		m.push_back(8'h00);
		put_fixed(m, 16'd0);
		put_label(m, 1);
		m.push_back(PTR_MASK);
		m.push_back(8'd12);
		put_fixed(m, 16'd1);
		put_random(m, 1);
		return m;
	endfunction

	task automatic test_record_walk();
		octet_q_t m;
		octet_q_t full;
		full = three_sections();
		send_message(full);
		// cut in the answer fixed part, then right after the authority name
		m = full[0:35];
		send_message(m);
		m = full[0:43];
		send_message(m);
		// pointer-like bytes after the complete answer name, taken as its fixed part
		m = full[0:28];
		m.push_back(PTR_MASK);
		m.push_back(8'hFF);
		send_message(m);
		// one byte after the last record, walked and then skipped
		m = full;
		m.push_back(8'h00);
		send_message(m);
		configure(1'b1, 1'b0, 1'b1);
		send_message(m);
		configure(1'b1, 1'b0, 1'b0);
	endtask

	// verdicts held back so the block fills and stops taking bytes
	task automatic test_backpressure();
		octet_q_t m;
		jitter_on = 1'b0;
		wait_idle();
		@(posedge clk);
		hold_req = 400;
		@(negedge clk);
		repeat (10) begin
			m = {};
			put_header(m, 16'($urandom), 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0);
			send_message(m);
		end
		wait_idle();
		jitter_on = 1'b1;
	endtask

	task automatic random_message();
		octet_q_t m;
		logic [15:0] flags;
		int qd;
		int nrec;
		int rdlen;
		int r;
		if ($urandom_range(0, 99) < 8) begin
			put_random(m, $urandom_range(1, 30));
		end else begin
			flags = 16'($urandom);
			if ($urandom_range(0, 4) != 0)
				flags[15] = acc_query ? (acc_resp ? 1'($urandom_range(0, 1)) : 1'b0) : 1'b1;
			r = $urandom_range(0, 19);
			qd = (r == 0) ? $urandom_range(2, 65535) : (r < 4) ? 0 : 1;
			nrec = 0;
			put16(m, 16'($urandom));
			put16(m, flags);
			put16(m, 16'(qd));
			for (int s = 0; s < 3; s++) begin
				r = $urandom_range(0, 3);
				nrec += r;
				put16(m, 16'(r));
			end
			if (qd == 1) begin
				put_random_name(m);
				put_random(m, 4);
			end
			repeat (nrec) begin
				put_random_name(m);
				rdlen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
				put_fixed(m, 16'(rdlen));
				put_random(m, rdlen);
			end
			// damage some messages: cut, bit flip or extra bytes
			r = $urandom_range(0, 99);
			if (r < 8) begin
				rdlen = $urandom_range(1, m.size() - 1);
				while (m.size() > rdlen) void'(m.pop_back());
			end else if (r < 14) begin
				rdlen = $urandom_range(0, m.size() - 1);
				m[rdlen] = m[rdlen] ^ (8'h01 << $urandom_range(0, 7));
			end else if (r < 19) begin
				put_random(m, $urandom_range(1, 4));
			end
		end
		send_message(m);
	endtask

	task automatic test_random_traffic();
		int msgs;
		msgs = 0;
		while (bytes_pushed < 1500) begin
			// new register setting every few messages
			if (msgs % 4 == 0) begin
				configure($urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)),
					$urandom_range(0, 4) == 0);
				jitter_on = $urandom_range(0, 5) != 0;
			end
			random_message();
			msgs++;
		end
		configure(1'b1, 1'b1, 1'b0);
		jitter_on = 1'b1;
	endtask

	// run watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("dns_message_wire_validator verification failed");
		$finish;
	end

	// test sequence
	initial begin
		clear_walk();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_header_and_qr();
		test_short_messages();
		test_question_counts();
		test_name_rules();
		test_record_walk();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (16) @(negedge clk);
		if (mismatch_count == 0 && verdict_q.size() == 0) begin
			$display("dns_message_wire_validator verification clean");
		end else begin
			$display("dns_message_wire_validator verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/dmwv_pkg.sv
rtl/core/dns_message_wire_validator.sv
rtl/core/dmwv_checker.sv
bench/tb_top.sv
